FILE: rtl/gh_pkg.sv
// shared constants, payload types and helpers for the gray-level histogram
package gh_pkg;

   localparam int PIXEL_BITS  = 8;
   localparam int COUNT_WIDTH = 24;
   localparam int NUM_BINS    = 1 << PIXEL_BITS;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef logic [PIXEL_BITS-1:0]  bin_addr_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] pixel_value;
      logic [7:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [7:0]  bin_number;
      logic [23:0] bin_count;
   } rsp_type;

   typedef struct packed {
      logic         en;
      bin_addr_type addr;
      count_type    data;
   } wr_type;

   // low bits of a gray level, zero extended when the bin range is wider
   function automatic bin_addr_type bin_of(input logic [7:0] level);
      logic [PIXEL_BITS+7:0] wide;
      wide = {{PIXEL_BITS{1'b0}}, level};
      return wide[PIXEL_BITS-1:0];
   endfunction

   function automatic logic [7:0] level_of(input bin_addr_type addr);
      logic [PIXEL_BITS+7:0] wide;
      wide = {8'd0, addr};
      return wide[7:0];
   endfunction

   function automatic logic [23:0] count_field(input count_type cnt);
      logic [COUNT_WIDTH+23:0] wide;
      wide = {24'd0, cnt};
      return wide[23:0];
   endfunction

   function automatic bin_addr_type req_addr(input req_type req);
      return (req.operation == OP_READ) ? bin_of(req.bin_index) : bin_of(req.pixel_value);
   endfunction

endpackage

FILE: rtl/grayscale_histogram_core.sv
// gray-level histogram: one read-modify-write per beat on a 256-entry bin memory
// throughput: one beat per cycle; a read beat stalls only while the result register is held
// a read beat passes the stage-one register, then its result is held in the result register
// registered memory read; modify and write back run from stage one; same-bin overlap is forwarded
// reset: synchronous, clears control and the per-bin written flags, so every bin reads zero at once
module grayscale_histogram_core
   import gh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   logic      fwd_hit_ff, fwd_hit_in;
   count_type fwd_data_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_data_ff;

   logic         accept;
   logic         s1_go;
   bin_addr_type in_addr;
   count_type    mem_q;
   count_type    operand;
   wr_type       wr;
   rsp_type      upd_rsp;

   assign s1_go = s1_valid_ff
                  && (s1_req_ff.operation == OP_COUNT || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign accept    = req_valid && req_ready;
   assign in_addr   = req_addr(req_data);

   gh_bin_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (in_addr),
      .rd_data (mem_q),
      .wr      (wr)
   );

   assign operand = fwd_hit_ff ? fwd_data_ff : mem_q;

   gh_update u_update (
      .commit  (s1_go),
      .item    (s1_req_ff),
      .operand (operand),
      .wr      (wr),
      .rsp     (upd_rsp)
   );

   // same-bin write in the read cycle
   assign fwd_hit_in = wr.en && (wr.addr == in_addr);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && s1_req_ff.operation == OP_READ) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff   <= req_data;
         fwd_data_ff <= wr.data;
      end
      if (s1_go && s1_req_ff.operation == OP_READ) begin
         rsp_data_ff <= upd_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_write_needs_item: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> s1_valid_ff)
      else $error("bin write without an item in flight");

   a_no_result_overrun: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_req_ff.operation == OP_READ) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while held");

   a_count_never_wraps: assert property (@(posedge clock) disable iff (reset)
      (wr.en && s1_req_ff.operation == OP_COUNT) |-> (wr.data != '0))
      else $error("bin count wrapped to zero");

   a_read_clears_bin: assert property (@(posedge clock) disable iff (reset)
      (wr.en && s1_req_ff.operation == OP_READ) |-> (wr.data == '0))
      else $error("read beat did not clear its bin");
`endif

endmodule

FILE: rtl/gh_bin_store.sv
// bin count memory with per-bin written flags, registered read
module gh_bin_store
   import gh_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         rd_en,
   input  bin_addr_type rd_addr,
   output count_type    rd_data,
   input  wr_type       wr
);

   count_type             mem [NUM_BINS];
   logic [NUM_BINS-1:0]   vld_ff;
   count_type             rd_data_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // never-written bins read as zero
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/gh_update.sv
// modify step: saturating increment or read-and-clear of one bin
module gh_update
   import gh_pkg::*;
(
   input  logic      commit,
   input  req_type   item,
   input  count_type operand,
   output wr_type    wr,
   output rsp_type   rsp
);

   bin_addr_type addr;

   assign addr = req_addr(item);

   always_comb begin
      wr.en   = commit;
      wr.addr = addr;
      if (item.operation == OP_READ) begin
         wr.data = '0;
      end else if (operand == COUNT_MAX) begin
         wr.data = operand;
      end else begin
         wr.data = operand + count_type'(1);
      end
   end

   assign rsp.bin_number = level_of(addr);
   assign rsp.bin_count  = count_field(operand);

endmodule
